/* hdl/tracked_entry_lifecycle_table_assert.svh */
// assertion macros used by the checker file
`ifndef TRACKED_ENTRY_LIFECYCLE_TABLE_ASSERT_SVH
`define TRACKED_ENTRY_LIFECYCLE_TABLE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TELT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TELT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/telt_pkg.sv */
package telt_pkg;

  // request operation codes
  localparam logic [2:0] FUNC_ADD    = 3'd0;
  localparam logic [2:0] FUNC_REMOVE = 3'd1;
  localparam logic [2:0] FUNC_CLEAR  = 3'd2;
  localparam logic [2:0] FUNC_TICK   = 3'd3;
  localparam logic [2:0] FUNC_QUERY  = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_UNTRACKED = 2'd2;
  localparam logic [1:0] STATUS_DUPLICATE = 2'd3;

  localparam int unsigned CountW = 9;
  localparam logic [CountW-1:0] COUNT_MAX = 9'd511;

  typedef enum logic [1:0] {
    PH_INCOMING = 2'd0,
    PH_TRACKING = 2'd1,
    PH_OUTGOING = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_FILL = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

endpackage

/* hdl/telt_cell.sv */
module telt_cell import telt_pkg::*; #(
  parameter int unsigned IDENT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic                  valid_i,
  input  logic [IDENT_BITS-1:0] ident_i,
  input  phase_e                phase_i,
  output logic                  valid_o,
  output logic [IDENT_BITS-1:0] ident_o,
  output phase_e                phase_o
);

  logic                  valid_q;
  logic [IDENT_BITS-1:0] ident_q;
  phase_e                phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= PH_INCOMING;
    end else if (shift_i) begin
      valid_q <= valid_i;
      phase_q <= phase_i;
    end
  end

  // identifier is only looked at while the slot is valid
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ident_q <= ident_i;
    end
  end

  assign valid_o = valid_q;
  assign ident_o = ident_q;
  assign phase_o = phase_q;

endmodule

/* hdl/tracked_entry_lifecycle_table.sv */
// sequence: a request is taken in idle, then one walk lap passes every slot by the update head;
//   an add that stores a new identifier makes a second lap, then the result is registered
// throughput: one request at a time, set by the ring of slot cells that rotates one slot
//   past the single update head per cycle; the result waits while an older one is stalled
// reset: all slot valid bits and phases clear at once, no clearing pass, no result pending
module tracked_entry_lifecycle_table import telt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned IDENT_BITS    = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request side
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        func_i,
  input  logic [15:0]       entity_id_i,
  // result side
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CountW-1:0] known_count_o,
  output logic              is_tracking_o,
  output logic              is_removing_o,
  output logic [1:0]        status_o
);

  localparam int unsigned CntW = $clog2(TABLE_ENTRIES);

  // ring of slot cells, the tail feeds the update head which feeds cell 0
  logic                  v_chain  [TABLE_ENTRIES];
  logic [IDENT_BITS-1:0] id_chain [TABLE_ENTRIES];
  phase_e                ph_chain [TABLE_ENTRIES];

  logic                  head_v;
  logic [IDENT_BITS-1:0] head_id;
  phase_e                head_ph;
  logic                  shift;

  for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_ring
    if (gi == 0) begin : g_first
      telt_cell #(.IDENT_BITS(IDENT_BITS)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .valid_i (head_v),
        .ident_i (head_id),
        .phase_i (head_ph),
        .valid_o (v_chain[gi]),
        .ident_o (id_chain[gi]),
        .phase_o (ph_chain[gi])
      );
    end else begin : g_next
      telt_cell #(.IDENT_BITS(IDENT_BITS)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .valid_i (v_chain[gi-1]),
        .ident_i (id_chain[gi-1]),
        .phase_i (ph_chain[gi-1]),
        .valid_o (v_chain[gi]),
        .ident_o (id_chain[gi]),
        .phase_o (ph_chain[gi])
      );
    end
  end

  // identifier of the incoming request, cut to IDENT_BITS bits or zero-extended above 16 bits
  logic [IDENT_BITS-1:0] id_in;
  if (IDENT_BITS <= 16) begin : g_id_narrow
    assign id_in = entity_id_i[IDENT_BITS-1:0];
  end else begin : g_id_wide
    assign id_in = {{(IDENT_BITS-16){1'b0}}, entity_id_i};
  end

  state_e                state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [2:0]            func_q;
  logic [IDENT_BITS-1:0] id_q;

  // walk accumulators
  logic              hit_q, hit_d;        // id seen before update
  logic              found_q, found_d;    // id present after update
  phase_e            found_ph_q, found_ph_d;
  logic              free_q, free_d;      // some slot was empty
  logic              ins_done_q, ins_done_d;
  logic [CountW-1:0] count_q, count_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] known_count_q;
  logic              is_tracking_q, is_removing_q;
  logic [1:0]        status_q;
  logic              load_out;

  logic                  tail_v;
  logic [IDENT_BITS-1:0] tail_id;
  phase_e                tail_ph;
  logic                  match_pre;
  logic                  last;

  assign tail_v    = v_chain[TABLE_ENTRIES-1];
  assign tail_id   = id_chain[TABLE_ENTRIES-1];
  assign tail_ph   = ph_chain[TABLE_ENTRIES-1];
  assign match_pre = tail_v && (tail_id == id_q);
  assign shift     = (state_q == S_WALK) || (state_q == S_FILL);
  assign last      = (cnt_q == CntW'(TABLE_ENTRIES - 1));
  assign in_stall_o = (state_q != S_IDLE);

  // update head: applies the request to the slot passing by
  always_comb begin
    head_v  = tail_v;
    head_id = tail_id;
    head_ph = tail_ph;
    if (state_q == S_WALK) begin
      case (func_q)
        FUNC_REMOVE, FUNC_CLEAR: begin
          // remove (matching slot) or clear (every valid slot) drops an incoming slot and retires a tracked one
          if ((func_q == FUNC_CLEAR && tail_v) || (func_q == FUNC_REMOVE && match_pre)) begin
            if (tail_ph == PH_INCOMING) begin
              head_v  = 1'b0;
              head_ph = PH_INCOMING;
            end else if (tail_ph == PH_TRACKING) begin
              head_ph = PH_OUTGOING;
            end
          end
        end
        FUNC_TICK: begin
          if (tail_v) begin
            if (tail_ph == PH_INCOMING) begin
              head_ph = PH_TRACKING;
            end else if (tail_ph == PH_OUTGOING) begin
              head_v  = 1'b0;
              head_ph = PH_INCOMING;
            end
          end
        end
        default: begin
          // add looks only, query changes nothing
        end
      endcase
    end else if (state_q == S_FILL) begin
      // second lap of an add: store into the first empty slot
      if (!tail_v && !ins_done_q) begin
        head_v  = 1'b1;
        head_id = id_q;
        head_ph = PH_INCOMING;
      end
    end
  end

  // accumulators and sequencing
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    found_d     = found_q;
    found_ph_d  = found_ph_q;
    free_d      = free_q;
    ins_done_d  = ins_done_q;
    count_d     = count_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d    = S_WALK;
          cnt_d      = '0;
          hit_d      = 1'b0;
          found_d    = 1'b0;
          found_ph_d = PH_INCOMING;
          free_d     = 1'b0;
          ins_done_d = 1'b0;
          count_d    = '0;
        end
      end
      S_WALK: begin
        cnt_d = cnt_q + CntW'(1);
        if (match_pre) begin
          hit_d = 1'b1;
        end
        if (!tail_v) begin
          free_d = 1'b1;
        end
        if (head_v && head_id == id_q) begin
          found_d    = 1'b1;
          found_ph_d = head_ph;
        end
        if (head_v && head_ph != PH_INCOMING && count_q != COUNT_MAX) begin
          count_d = count_q + CountW'(1);
        end
        if (last) begin
          cnt_d = '0;
          if (func_q == FUNC_ADD && !found_d && free_d) begin
            state_d = S_FILL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_FILL: begin
        cnt_d = cnt_q + CntW'(1);
        if (!tail_v) begin
          ins_done_d = 1'b1;
        end
        if (last) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // wait here while an older result is still held
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      ins_done_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      ins_done_q  <= ins_done_d;
    end
  end

  // request capture and walk payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      func_q <= func_i;
      id_q   <= id_in;
    end
    hit_q      <= hit_d;
    found_q    <= found_d;
    found_ph_q <= found_ph_d;
    free_q     <= free_d;
    count_q    <= count_d;
  end

  // result fields from the finished walk
  logic       add_stored;
  logic [1:0] status_nx;

  assign add_stored = (func_q == FUNC_ADD) && !found_q && free_q;

  always_comb begin
    status_nx = STATUS_OK;
    if (func_q == FUNC_ADD) begin
      if (found_q) begin
        status_nx = STATUS_DUPLICATE;
      end else if (!free_q) begin
        status_nx = STATUS_FULL;
      end
    end else if (func_q == FUNC_REMOVE && !hit_q) begin
      status_nx = STATUS_UNTRACKED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      known_count_q <= count_q;
      is_tracking_q <= add_stored || (found_q && found_ph_q != PH_OUTGOING);
      is_removing_q <= found_q && found_ph_q == PH_OUTGOING;
      status_q      <= status_nx;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign known_count_o = known_count_q;
  assign is_tracking_o = is_tracking_q;
  assign is_removing_o = is_removing_q;
  assign status_o      = status_q;

endmodule

/* hdl/telt_checker.sv */
`include "tracked_entry_lifecycle_table_assert.svh"

module telt_checker import telt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [2:0]        func_i,
  input logic [15:0]       entity_id_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CountW-1:0] known_count_o,
  input logic              is_tracking_o,
  input logic              is_removing_o,
  input logic [1:0]        status_o
);

  `TELT_ASSERT_NOW(a_phase_excl, clk_i, rst_ni, out_valid_o, !(is_tracking_o && is_removing_o), "id both tracked and removing")
  `TELT_ASSERT_NOW(a_full_absent, clk_i, rst_ni, out_valid_o && status_o == STATUS_FULL, !is_tracking_o && !is_removing_o, "full add reports id present")
  `TELT_ASSERT_NOW(a_dup_present, clk_i, rst_ni, out_valid_o && status_o == STATUS_DUPLICATE, is_tracking_o || is_removing_o, "duplicate add reports id absent")
  `TELT_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "second request taken during walk")
  `TELT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(known_count_o) && $stable(status_o), "stalled result changed")

endmodule

bind tracked_entry_lifecycle_table telt_checker u_telt_checker (.*);
